### src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define BWW_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BWW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bww_pkg.sv
// ----------------------------------------------------------------------------
// bww_pkg
// Shared types and constants of the BMP24 to RGB565 window writer.
// ----------------------------------------------------------------------------
package bww_pkg;

    localparam int DISPLAY_WIDTH_DEF   = 240;
    localparam int DISPLAY_HEIGHT_DEF  = 320;
    localparam int MAX_IMAGE_WIDTH_DEF = 1280;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_PARAM  = 2'd1;
    localparam logic [1:0] KIND_PIXEL  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_PLANES   = 3'd1;
    localparam logic [2:0] STAT_DEPTH    = 3'd2;
    localparam logic [2:0] STAT_COMPRESS = 3'd3;
    localparam logic [2:0] STAT_WIDTH    = 3'd4;
    localparam logic [2:0] STAT_HEIGHT   = 3'd5;

    // One job: all results caused by one input byte.
    typedef struct packed {
        logic        cmd_v;
        logic        pix_v;
        logic        stat_v;
        logic [2:0]  stat_code;
        logic [8:0]  xs;
        logic [8:0]  xe;
        logic [9:0]  y;
        logic [15:0] pix;
    } job_t;

endpackage

### src/bww_channels.sv
// ----------------------------------------------------------------------------
// bww channels
// Valid/ready channel interfaces for input bytes and output writes.
// ----------------------------------------------------------------------------
interface bww_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] bmp_byte;
    logic       image_start;
    modport source (output valid, output bmp_byte, output image_start, input ready);
    modport sink   (input valid, input bmp_byte, input image_start, output ready);
endinterface

interface bww_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  write_kind;
    logic [15:0] write_value;
    logic        last;
    modport source (output valid, output write_kind, output write_value, output last,
                    input ready);
    modport sink   (input valid, input write_kind, input write_value, input last,
                    output ready);
endinterface

### src/bww_front.sv
// ----------------------------------------------------------------------------
// bww_front
// Byte parser: header decode, checks, windowing and pixel packing into jobs.
// ----------------------------------------------------------------------------
module bww_front #(
    parameter int DISPLAY_WIDTH   = bww_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT  = bww_pkg::DISPLAY_HEIGHT_DEF,
    parameter int MAX_IMAGE_WIDTH = bww_pkg::MAX_IMAGE_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    bww_in_if.sink          in_ch,
    input  logic [7:0]      column_offset,
    input  logic [7:0]      row_offset,
    input  logic            full,
    output logic            push,
    output bww_pkg::job_t   job
);

    localparam logic [2:0] MODE_HEADER = 3'd0;
    localparam logic [2:0] MODE_WAIT   = 3'd1;
    localparam logic [2:0] MODE_DATA   = 3'd2;
    localparam logic [2:0] MODE_DONE   = 3'd3;
    localparam logic [2:0] MODE_ERROR  = 3'd4;

    localparam logic [7:0]  DW8  = 8'(DISPLAY_WIDTH);
    localparam logic [8:0]  DH9  = 9'(DISPLAY_HEIGHT);
    localparam logic [31:0] DW32 = 32'(DISPLAY_WIDTH);
    localparam logic [31:0] DH32 = 32'(DISPLAY_HEIGHT);
    localparam logic [31:0] MW32 = 32'(MAX_IMAGE_WIDTH);

    logic [31:0] pos_reg, pos_next;
    logic [2:0]  mode_reg, mode_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [31:0] chk_reg, chk_next;
    logic [12:0] padded_reg, padded_next;
    logic [31:0] skip_reg, skip_next;
    logic [7:0]  wxs_reg, wxs_next;
    logic [7:0]  wxe_reg, wxe_next;
    logic [8:0]  wys_reg, wys_next;
    logic [8:0]  cur_reg, cur_next;
    logic [12:0] bir_reg, bir_next;
    logic [10:0] pp_reg, pp_next;
    logic [1:0]  phase_reg, phase_next;
    logic [9:0]  pixb_reg, pixb_next;

    logic        accept;
    logic [31:0] p;
    logic [31:0] sh;
    logic [1:0]  lane;
    logic [7:0]  b;
    logic [7:0]  w;
    logic [12:0] tmp3;
    logic        run_data;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && !full;
    assign b           = in_ch.bmp_byte;

    always_comb
    begin
        pos_next = pos_reg;     mode_next = mode_reg;     off_next = off_reg;
        width_next = width_reg; height_next = height_reg; chk_next = chk_reg;
        padded_next = padded_reg; skip_next = skip_reg;   wxs_next = wxs_reg;
        wxe_next = wxe_reg;     wys_next = wys_reg;       cur_next = cur_reg;
        bir_next = bir_reg;     pp_next = pp_reg;         phase_next = phase_reg;
        pixb_next = pixb_reg;
        job = '0;
        p = pos_reg;
        lane = 2'd0; sh = '0; w = '0; tmp3 = '0; run_data = 1'b0;
        if (accept)
        begin
            if (in_ch.image_start)
            begin
                pos_next = '0;    mode_next = MODE_HEADER; off_next = '0;
                width_next = '0;  height_next = '0;        chk_next = '0;
                padded_next = '0; skip_next = '0;          wxs_next = '0;
                wxe_next = '0;    wys_next = '0;           cur_next = '0;
                bir_next = '0;    pp_next = '0;            phase_next = '0;
                pixb_next = '0;
            end
            p = pos_next;
            if (p != 32'hFFFF_FFFF)
                pos_next = p + 32'd1;

            if (mode_next == MODE_HEADER)
            begin
                // all fields start at a position that is 2 mod 4
                lane = p[1:0] - 2'd2;
                sh   = 32'(b) << {lane, 3'b000};
                if (p >= 32'd10 && p <= 32'd13)      off_next    = off_next | sh;
                else if (p >= 32'd18 && p <= 32'd21) width_next  = width_next | sh;
                else if (p >= 32'd22 && p <= 32'd25) height_next = height_next | sh;
                else if (p >= 32'd26 && p <= 32'd29) chk_next    = chk_next | sh;
                else if (p >= 32'd30 && p <= 32'd33) chk_next    = chk_next | 32'(b);

                if (p == 32'd29)
                begin
                    if (chk_next[15:0] != 16'd1)
                    begin
                        job.stat_v = 1'b1; job.stat_code = bww_pkg::STAT_PLANES;
                        mode_next = MODE_ERROR;
                    end
                    else if (chk_next[31:16] != 16'd24)
                    begin
                        job.stat_v = 1'b1; job.stat_code = bww_pkg::STAT_DEPTH;
                        mode_next = MODE_ERROR;
                    end
                    else
                        chk_next = '0;
                end
                else if (p == 32'd33)
                begin
                    if (chk_next != 32'd0)
                    begin
                        job.stat_v = 1'b1; job.stat_code = bww_pkg::STAT_COMPRESS;
                        mode_next = MODE_ERROR;
                    end
                    else if (width_next == 32'd0 || width_next > MW32)
                    begin
                        job.stat_v = 1'b1; job.stat_code = bww_pkg::STAT_WIDTH;
                        mode_next = MODE_ERROR;
                    end
                    else if (height_next == 32'd0)
                    begin
                        job.stat_v = 1'b1; job.stat_code = bww_pkg::STAT_HEIGHT;
                        mode_next = MODE_ERROR;
                    end
                    else
                    begin
                        tmp3 = width_next[12:0] + {width_next[11:0], 1'b0} + 13'd3;
                        padded_next = {tmp3[12:2], 2'b00};
                        if (width_next > DW32)
                        begin
                            wxs_next = '0; w = DW8;
                        end
                        else
                        begin
                            wxs_next = (DW8 - width_next[7:0]) >> 1;
                            w = width_next[7:0];
                        end
                        wxe_next  = wxs_next + w - 8'd1;
                        pixb_next = {2'b00, w} + {1'b0, w, 1'b0};
                        if (height_next > DH32)
                        begin
                            wys_next  = '0;
                            cur_next  = DH9 - 9'd1;
                            skip_next = height_next - DH32;
                        end
                        else
                        begin
                            wys_next  = (DH9 - height_next[8:0]) >> 1;
                            cur_next  = wys_next + height_next[8:0] - 9'd1;
                            skip_next = '0;
                        end
                        bir_next = '0; phase_next = '0; pp_next = '0;
                        mode_next = MODE_WAIT;
                    end
                end
            end
            else if (mode_next == MODE_WAIT)
            begin
                if (p >= off_next)
                begin
                    mode_next = MODE_DATA;
                    run_data  = 1'b1;
                end
            end
            else if (mode_next == MODE_DATA)
                run_data = 1'b1;

            if (run_data)
            begin
                if (skip_next != 32'd0)
                begin
                    bir_next = bir_next + 13'd1;
                    if (bir_next >= padded_next)
                    begin
                        bir_next  = '0;
                        skip_next = skip_next - 32'd1;
                    end
                end
                else
                begin
                    if (bir_next == 13'd0)
                    begin
                        job.cmd_v = 1'b1;
                        job.xs = {1'b0, column_offset} + {1'b0, wxs_next};
                        job.xe = {1'b0, column_offset} + {1'b0, wxe_next};
                        job.y  = {2'b00, row_offset} + {1'b0, cur_next};
                    end
                    if (bir_next < {3'b000, pixb_next})
                    begin
                        unique case (phase_next)
                            2'd0:
                            begin
                                pp_next = {6'd0, b[7:3]}; phase_next = 2'd1;
                            end
                            2'd1:
                            begin
                                pp_next = pp_next | {b[7:2], 5'd0}; phase_next = 2'd2;
                            end
                            default:
                            begin
                                job.pix_v = 1'b1;
                                job.pix   = {b[7:3], pp_next};
                                pp_next = '0; phase_next = 2'd0;
                            end
                        endcase
                    end
                    bir_next = bir_next + 13'd1;
                    if (bir_next >= padded_next)
                    begin
                        bir_next = '0; phase_next = '0; pp_next = '0;
                        if (cur_next <= wys_next)
                        begin
                            job.stat_v = 1'b1; job.stat_code = bww_pkg::STAT_OK;
                            mode_next = MODE_DONE;
                        end
                        else
                            cur_next = cur_next - 9'd1;
                    end
                end
            end
        end
    end

    assign push = accept && (job.cmd_v || job.pix_v || job.stat_v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;    mode_reg <= MODE_HEADER; off_reg <= '0;
            width_reg <= '0;  height_reg <= '0;        chk_reg <= '0;
            padded_reg <= '0; skip_reg <= '0;          wxs_reg <= '0;
            wxe_reg <= '0;    wys_reg <= '0;           cur_reg <= '0;
            bir_reg <= '0;    pp_reg <= '0;            phase_reg <= '0;
            pixb_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;       mode_reg <= mode_next;     off_reg <= off_next;
            width_reg <= width_next;   height_reg <= height_next; chk_reg <= chk_next;
            padded_reg <= padded_next; skip_reg <= skip_next;     wxs_reg <= wxs_next;
            wxe_reg <= wxe_next;       wys_reg <= wys_next;       cur_reg <= cur_next;
            bir_reg <= bir_next;       pp_reg <= pp_next;         phase_reg <= phase_next;
            pixb_reg <= pixb_next;
        end
    end

endmodule

### src/bww_queue.sv
// ----------------------------------------------------------------------------
// bww_queue
// Short job queue between parser and write sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bww_queue #(
    parameter int DEPTH = bww_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bww_pkg::job_t wr_job,
    output logic          full,
    input  logic          pop,
    output logic          rd_valid,
    output bww_pkg::job_t rd_job
);

    localparam int AW = $clog2(DEPTH);

    bww_pkg::job_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg, cnt_next;

    assign full     = cnt_reg == (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_job   = mem[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    `BWW_ASSERT(a_no_push_full, !(push && full), "push into full queue")
    `BWW_ASSERT(a_no_pop_empty, !(pop && !rd_valid), "pop from empty queue")

endmodule

### src/bww_back.sv
// ----------------------------------------------------------------------------
// bww_back
// Write sequencer: expands one job into command, parameter, pixel, status beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bww_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_valid,
    input  bww_pkg::job_t rd_job,
    output logic          pop,
    bww_out_if.source     out_ch
);

    localparam logic [3:0] IDX_CASET = 4'd0;
    localparam logic [3:0] IDX_RASET = 4'd5;
    localparam logic [3:0] IDX_RAMWR = 4'd10;
    localparam logic [3:0] IDX_PIX   = 4'd11;
    localparam logic [3:0] IDX_STAT  = 4'd12;

    bww_pkg::job_t job_reg;
    logic          jv_reg;
    logic [3:0]    idx_reg, idx_next, start_idx;
    logic          ov_reg;
    logic [1:0]    kind_reg, kind_c;
    logic [15:0]   val_reg, val_c;
    logic          last_reg, last_c;
    logic          adv;

    assign adv = jv_reg && (!ov_reg || out_ch.ready);
    assign pop = rd_valid && (!jv_reg || (adv && last_c));

    always_comb
    begin
        start_idx = rd_job.cmd_v ? IDX_CASET : (rd_job.pix_v ? IDX_PIX : IDX_STAT);
        if (idx_reg < IDX_RAMWR)
            idx_next = idx_reg + 4'd1;
        else if (idx_reg == IDX_RAMWR && job_reg.pix_v)
            idx_next = IDX_PIX;
        else
            idx_next = IDX_STAT;
        last_c = (idx_reg == IDX_STAT)
              || (idx_reg == IDX_PIX && !job_reg.stat_v)
              || (idx_reg == IDX_RAMWR && !job_reg.pix_v && !job_reg.stat_v);
    end

    always_comb
    begin
        kind_c = bww_pkg::KIND_PARAM;
        val_c  = '0;
        unique case (idx_reg)
            IDX_CASET: begin kind_c = bww_pkg::KIND_CMD; val_c = 16'(bww_pkg::CMD_CASET); end
            4'd1:      val_c = 16'(job_reg.xs[8]);
            4'd2:      val_c = 16'(job_reg.xs[7:0]);
            4'd3:      val_c = 16'(job_reg.xe[8]);
            4'd4:      val_c = 16'(job_reg.xe[7:0]);
            IDX_RASET: begin kind_c = bww_pkg::KIND_CMD; val_c = 16'(bww_pkg::CMD_RASET); end
            4'd6:      val_c = 16'(job_reg.y[9:8]);
            4'd7:      val_c = 16'(job_reg.y[7:0]);
            4'd8:      val_c = 16'(job_reg.y[9:8]);
            4'd9:      val_c = 16'(job_reg.y[7:0]);
            IDX_RAMWR: begin kind_c = bww_pkg::KIND_CMD; val_c = 16'(bww_pkg::CMD_RAMWR); end
            IDX_PIX:   begin kind_c = bww_pkg::KIND_PIXEL; val_c = job_reg.pix; end
            default:   begin kind_c = bww_pkg::KIND_STATUS; val_c = 16'(job_reg.stat_code); end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jv_reg  <= 1'b0;
            idx_reg <= IDX_CASET;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                jv_reg  <= 1'b1;
                idx_reg <= start_idx;
            end
            else if (adv && last_c)
                jv_reg <= 1'b0;
            else if (adv)
                idx_reg <= idx_next;

            if (adv)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= rd_job;
        if (adv)
        begin
            kind_reg <= kind_c;
            val_reg  <= val_c;
            last_reg <= last_c;
        end
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.write_kind  = kind_reg;
    assign out_ch.write_value = val_reg;
    assign out_ch.last        = last_reg;

    `BWW_ASSERT(a_idx_range, !jv_reg || idx_reg <= IDX_STAT, "sequencer index out of range")
    `BWW_ASSERT_NEXT(a_stall_hold, ov_reg && !out_ch.ready, ov_reg, "beat dropped under stall")

endmodule

### src/bmp24_to_rgb565_window_writer.sv
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_window_writer
// Parses a 24-bit BMP byte stream and writes windowed RGB565 rows to a panel.
// ----------------------------------------------------------------------------
// Throughput: one file byte per cycle; the parser stalls only when the job queue is full.
// A row's first byte yields 11 beats (window commands), pixel bytes 1 beat per 3 bytes.
// Output path: a byte's results pass the queue write, the sequencer load and the output
// register before the first beat is valid; further beats follow 1 per cycle while the
// output is not stalled by out_ch.ready. Reset: asynchronous, clears offsets and the
// parser to header mode at position 0. No clearing pass; bytes are taken right after reset.
module bmp24_to_rgb565_window_writer #(
    parameter int DISPLAY_WIDTH   = bww_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT  = bww_pkg::DISPLAY_HEIGHT_DEF,
    parameter int MAX_IMAGE_WIDTH = bww_pkg::MAX_IMAGE_WIDTH_DEF,
    parameter int QUEUE_DEPTH     = bww_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bww_in_if.sink      in_ch,
    bww_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Panel offsets: register 0 at byte 0, register 1 at byte 4.
    logic [7:0] col_off_reg;
    logic [7:0] row_off_reg;

    logic          q_push, q_full, q_pop, q_rd_valid;
    bww_pkg::job_t q_wr_job, q_rd_job;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {24'd0, row_off_reg} : {24'd0, col_off_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_off_reg <= '0;
            row_off_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
                row_off_reg <= pwdata[7:0];
            else
                col_off_reg <= pwdata[7:0];
        end
    end

    // Front: header parse, window setup, pixel packing; one job per byte with results.
    bww_front #(
        .DISPLAY_WIDTH   (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT  (DISPLAY_HEIGHT),
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .column_offset (col_off_reg),
        .row_offset    (row_off_reg),
        .full          (q_full),
        .push          (q_push),
        .job           (q_wr_job)
    );

    // Queue absorbs the 11-beat command burst at each row start.
    bww_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_job   (q_wr_job),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_rd_valid),
        .rd_job   (q_rd_job)
    );

    // Back: one beat per cycle, unless out_ch.ready stalls it, into a registered output stage.
    bww_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (q_rd_valid),
        .rd_job   (q_rd_job),
        .pop      (q_pop),
        .out_ch   (out_ch)
    );

endmodule
